[rtl/qgs_pkg.sv]
`timescale 1ns / 1ps
// qgs_pkg: shared constants, controller states and command/status structs
// for the quad grid subdivider; depends on nothing
package qgs_pkg;

  localparam int MAX_SIDE_TILES_DEF = 4;
  localparam int COORD_BITS_DEF     = 32;
  localparam int CFG_W              = 31;
  localparam int CNT_W              = 3;
  localparam int IDX_W              = 2;
  localparam int DEN_W              = 6;
  localparam logic [CFG_W-1:0] MAX_SIZE_RST = 31'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_ADD,
    S_K_MUL,
    S_K_CMP,
    S_TERM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             side_init;
    logic             sq_mul;
    logic             sq_add;
    logic             k_mul;
    logic             t_step;
    logic             side;
    logic [1:0]       comp;
    logic             term_en;
    logic [1:0]       term;
    logic             div_start;
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
    logic [CNT_W-1:0] ga;
    logic [CNT_W-1:0] gb;
  } dp_cmd_t;

  typedef struct packed {
    logic le;
    logic div_done;
  } dp_stat_t;

endpackage

[rtl/quad_grid_subdivider_top.sv]
`timescale 1ns / 1ps
// quad_grid_subdivider_top: splits a 3D rectangle into a tile grid, one corner per result
// depends on qgs_pkg, qgs_ctrl, qgs_dp
//
// usage:
//   input request: twelve signed Q16.16 corner coordinates p0..p3, taken on
//   in_valid with in_stall low; in_stall is high from acceptance until the
//   last corner of that rectangle has been taken
//   output request: pos_x/y/z with tile_a, tile_b, corner, last_item and
//   clipped, 4*A*B requests per rectangle, a-major then b then corner
//   config: max_size written on cfg_we; the user must write it only while idle, the block does not enforce this
// sequence:
//   count phase: per edge the squared edge length, then a multiply and compare per tile count k tried
//   each corner: the blend terms p0..p3 accumulated, a divider start, the divide,
//   then the output; the bit-serial divider sets the corner rate
// reset: rst clears the controller to idle and max_size to 1.0
// stall: a result is held unchanged on the outputs while out_stall is high
module quad_grid_subdivider_top #(
  parameter int MAX_SIDE_TILES = qgs_pkg::MAX_SIDE_TILES_DEF,
  parameter int COORD_BITS     = qgs_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [qgs_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] p0_x,
  input  logic signed [COORD_BITS-1:0] p0_y,
  input  logic signed [COORD_BITS-1:0] p0_z,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p1_z,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p2_z,
  input  logic signed [COORD_BITS-1:0] p3_x,
  input  logic signed [COORD_BITS-1:0] p3_y,
  input  logic signed [COORD_BITS-1:0] p3_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pos_x,
  output logic signed [COORD_BITS-1:0] pos_y,
  output logic signed [COORD_BITS-1:0] pos_z,
  output logic [qgs_pkg::IDX_W-1:0]    tile_a,
  output logic [qgs_pkg::IDX_W-1:0]    tile_b,
  output logic [qgs_pkg::IDX_W-1:0]    corner,
  output logic                         last_item,
  output logic                         clipped
);
  import qgs_pkg::*;

  dp_cmd_t                     cmd;
  dp_stat_t                    stat;
  logic signed [COORD_BITS-1:0] pin [4][3];
  logic signed [COORD_BITS-1:0] pos [3];

  assign pin[0][0] = p0_x;
  assign pin[0][1] = p0_y;
  assign pin[0][2] = p0_z;
  assign pin[1][0] = p1_x;
  assign pin[1][1] = p1_y;
  assign pin[1][2] = p1_z;
  assign pin[2][0] = p2_x;
  assign pin[2][1] = p2_y;
  assign pin[2][2] = p2_z;
  assign pin[3][0] = p3_x;
  assign pin[3][1] = p3_y;
  assign pin[3][2] = p3_z;

  assign pos_x = pos[0];
  assign pos_y = pos[1];
  assign pos_z = pos[2];

  qgs_ctrl #(
    .MAX_SIDE_TILES(MAX_SIDE_TILES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .stat     (stat),
    .tile_a   (tile_a),
    .tile_b   (tile_b),
    .corner   (corner),
    .last_item(last_item),
    .clipped  (clipped)
  );

  qgs_dp #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .pin      (pin),
    .cmd      (cmd),
    .stat     (stat),
    .pos      (pos)
  );

endmodule

[rtl/qgs_div.sv]
`timescale 1ns / 1ps
// qgs_div: bit-serial floor divider of a signed value by a small positive divisor
// depends on nothing
module qgs_div #(
  parameter int NW = 38,
  parameter int DW = 6,
  parameter int QW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic [QW-1:0]        q
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quot;
  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic          neg;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   r2;
  logic          ge;
  logic [NW-1:0] qfull;

  assign r2    = {rem, quot[NW-1]};
  assign ge    = r2 >= {1'b0, dreg};
  assign qfull = neg ? (~quot + NW'(1)) : quot;
  assign q     = qfull[QW-1:0];
  assign done  = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[NW-1];
      dreg <= den;
      rem  <= '0;
      if (num[NW-1]) begin
        quot <= (~num + NW'(1)) + NW'(den) - NW'(1);
      end else begin
        quot <= num;
      end
    end else if (busy) begin
      rem  <= ge ? DW'(r2 - {1'b0, dreg}) : DW'(r2);
      quot <= {quot[NW-2:0], ge};
    end
  end

endmodule

[rtl/qgs_dp.sv]
`timescale 1ns / 1ps
// qgs_dp: corner store, edge length and tile size compare, blend accumulate
// depends on qgs_pkg and qgs_div
module qgs_dp #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [qgs_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic signed [COORD_BITS-1:0] pin [4][3],
  input  qgs_pkg::dp_cmd_t             cmd,
  output qgs_pkg::dp_stat_t            stat,
  output logic signed [COORD_BITS-1:0] pos [3]
);
  import qgs_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int OPW = (CB + 1 > CFG_W + 2) ? CB + 1 : CFG_W + 2;
  localparam int PW  = 2 * OPW;
  localparam int AW  = PW + 2;
  localparam int NW  = CB + 6;

  function automatic logic [CB:0] abs_diff(input logic signed [CB-1:0] a,
                                           input logic signed [CB-1:0] b);
    logic signed [CB:0] d;
    d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
    return d[CB] ? (~d + (CB+1)'(1)) : d;
  endfunction

  logic [CFG_W-1:0]       max_size;
  logic signed [CB-1:0]   pts [4][3];
  logic [CB:0]            dreg [2][3];
  logic [OPW-1:0]         t;
  logic [OPW-1:0]         op;
  logic [PW-1:0]          prod;
  logic [AW-1:0]          acc;
  logic signed [NW-1:0]   n [3];
  logic signed [NW-1:0]   num [3];
  logic [CNT_W-1:0]       wa;
  logic [CNT_W-1:0]       wb;
  logic [5:0]             wfull;
  logic [4:0]             ab;
  logic [2:0]             done_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= MAX_SIZE_RST;
    end else if (cfg_we) begin
      max_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pts <= pin;
      for (int c = 0; c < 3; c++) begin
        dreg[0][c] <= abs_diff(pin[1][c], pin[0][c]);
        dreg[1][c] <= abs_diff(pin[2][c], pin[1][c]);
      end
    end
  end

  assign op = cmd.sq_mul ? OPW'(dreg[cmd.side][cmd.comp]) : t;

  always_ff @(posedge clk) begin
    if (cmd.side_init) begin
      t   <= OPW'(max_size);
      acc <= '0;
    end else begin
      if (cmd.t_step) begin
        t <= t + OPW'(max_size);
      end
      if (cmd.sq_add) begin
        acc <= acc + AW'(prod);
      end
    end
    if (cmd.sq_mul || cmd.k_mul) begin
      prod <= op * op;
    end
  end

  assign stat.le = acc <= AW'(prod);

  always_comb begin
    case (cmd.term)
      2'd0: begin
        wa = cmd.cnt_a - cmd.ga;
        wb = cmd.cnt_b - cmd.gb;
      end
      2'd1: begin
        wa = cmd.ga;
        wb = cmd.cnt_b - cmd.gb;
      end
      2'd2: begin
        wa = cmd.ga;
        wb = cmd.gb;
      end
      default: begin
        wa = cmd.cnt_a - cmd.ga;
        wb = cmd.gb;
      end
    endcase
  end

  assign wfull = wa * wb;
  assign ab    = 5'(cmd.cnt_a * cmd.cnt_b);

  always_ff @(posedge clk) begin
    if (cmd.term_en) begin
      for (int c = 0; c < 3; c++) begin
        n[c] <= ((cmd.term == 2'd0) ? NW'(0) : n[c])
              + NW'($signed({1'b0, wfull[4:0]}) * pts[cmd.term][c]);
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    assign num[c] = (n[c] <<< 1) + $signed(NW'(ab));
    qgs_div #(
      .NW(NW),
      .DW(DEN_W),
      .QW(CB)
    ) u_div (
      .clk  (clk),
      .rst  (rst),
      .start(cmd.div_start),
      .num  (num[c]),
      .den  ({ab, 1'b0}),
      .done (done_v[c]),
      .q    (pos[c])
    );
  end

  assign stat.div_done = &done_v;

endmodule

[rtl/qgs_ctrl.sv]
`timescale 1ns / 1ps
// qgs_ctrl: sequencer for tile counting and corner emission
// depends on qgs_pkg
module qgs_ctrl #(
  parameter int MAX_SIDE_TILES = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  logic                        out_stall,
  output qgs_pkg::dp_cmd_t            cmd,
  input  qgs_pkg::dp_stat_t           stat,
  output logic [qgs_pkg::IDX_W-1:0]   tile_a,
  output logic [qgs_pkg::IDX_W-1:0]   tile_b,
  output logic [qgs_pkg::IDX_W-1:0]   corner,
  output logic                        last_item,
  output logic                        clipped
);
  import qgs_pkg::*;

  localparam logic [CNT_W-1:0] K_MAX = CNT_W'(MAX_SIDE_TILES);

  state_t           state;
  state_t           state_next;
  logic             side;
  logic [1:0]       comp;
  logic [1:0]       term;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] cnt_b;
  logic [IDX_W-1:0] ia;
  logic [IDX_W-1:0] ib;
  logic [IDX_W-1:0] cn;
  logic             clip;
  logic             k_done;
  logic             last;
  logic             b_end;

  assign k_done = stat.le || (k == K_MAX);
  assign b_end  = ({1'b0, ib} + CNT_W'(1)) == cnt_b;
  assign last   = (({1'b0, ia} + CNT_W'(1)) == cnt_a) && b_end && (cn == 2'd3);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_SQ_MUL;
      S_SQ_MUL:   state_next = S_SQ_ADD;
      S_SQ_ADD:   state_next = (comp == 2'd2) ? S_K_MUL : S_SQ_MUL;
      S_K_MUL:    state_next = S_K_CMP;
      S_K_CMP: begin
        if (k_done) state_next = side ? S_TERM : S_SQ_MUL;
        else        state_next = S_K_MUL;
      end
      S_TERM:     if (term == 2'd3) state_next = S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (stat.div_done) state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) state_next = last ? S_IDLE : S_TERM;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.side      = side;
    cmd.comp      = comp;
    cmd.term      = term;
    cmd.cnt_a     = cnt_a;
    cmd.cnt_b     = cnt_b;
    cmd.ga        = {1'b0, ia} + CNT_W'((cn == 2'd1) || (cn == 2'd2));
    cmd.gb        = {1'b0, ib} + CNT_W'(cn[1]);
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.side_init = cmd.load || ((state == S_K_CMP) && k_done && !side);
    cmd.sq_mul    = state == S_SQ_MUL;
    cmd.sq_add    = state == S_SQ_ADD;
    cmd.k_mul     = state == S_K_MUL;
    cmd.t_step    = (state == S_K_CMP) && !k_done;
    cmd.term_en   = state == S_TERM;
    cmd.div_start = state == S_DIV_GO;
    in_stall      = state != S_IDLE;
    out_valid     = state == S_OUT;
    tile_a        = ia;
    tile_b        = ib;
    corner        = cn;
    last_item     = last;
    clipped       = clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= 1'b0;
      comp  <= '0;
      term  <= '0;
      k     <= '0;
      cnt_a <= '0;
      cnt_b <= '0;
      ia    <= '0;
      ib    <= '0;
      cn    <= '0;
      clip  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            side <= 1'b0;
            comp <= '0;
            clip <= 1'b0;
          end
        end
        S_SQ_ADD: begin
          if (comp == 2'd2) begin
            comp <= '0;
            k    <= CNT_W'(1);
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_K_CMP: begin
          if (k_done) begin
            clip <= clip | !stat.le;
            if (!side) begin
              cnt_a <= k;
              side  <= 1'b1;
            end else begin
              cnt_b <= k;
              ia    <= '0;
              ib    <= '0;
              cn    <= '0;
              term  <= '0;
            end
          end else begin
            k <= k + CNT_W'(1);
          end
        end
        S_TERM: term <= term + 2'd1;
        S_OUT: begin
          if (!out_stall && !last) begin
            cn <= cn + 2'd1;
            if (cn == 2'd3) begin
              if (b_end) begin
                ib <= '0;
                ia <= ia + 2'd1;
              end else begin
                ib <= ib + 2'd1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
